### design/rxlrb_pkg.sv
// ----------------------------------------------------------------------------
// rxlrb_pkg
// Shared types and constants for the line-framed receive ring buffer.
// ----------------------------------------------------------------------------
package rxlrb_pkg;

	// item opcodes
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_LINE = 1'b1;

	// result status codes
	localparam logic STATUS_DATA    = 1'b0;
	localparam logic STATUS_NO_LINE = 1'b1;

	localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_COUNT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_CHAR_A = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_CHAR_B = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_CHAR_C = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_CHAR_D = 3'd4;

	localparam int NUM_IGNORE = 4;

	typedef struct packed {
		logic       op;
		logic [7:0] data;
	} cmd_t;

	// head of the front-to-back command queue
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmdq_t;

	typedef struct packed {
		logic       status;
		logic [7:0] line_byte;
		logic       last_byte;
	} rsp_t;

	typedef enum logic {
		BK_IDLE,
		BK_STREAM
	} back_state_t;

endpackage

### design/rxlrb_ifs.sv
// ----------------------------------------------------------------------------
// rxlrb channel interfaces
// Valid/ready channels for incoming items and outgoing line results.
// ----------------------------------------------------------------------------
interface rxlrb_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] rx_byte;

	modport source (output valid, output op, output rx_byte, input ready);
	modport sink (input valid, input op, input rx_byte, output ready);
endinterface

interface rxlrb_out_if;
	logic       valid;
	logic       ready;
	logic       status;
	logic [7:0] line_byte;
	logic       last_byte;

	modport source (output valid, output status, output line_byte, output last_byte,
		input ready);
	modport sink (input valid, input status, input line_byte, input last_byte,
		output ready);
endinterface

### design/rxlrb_ram.sv
// ----------------------------------------------------------------------------
// rxlrb_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module rxlrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### design/rxlrb_front.sv
// ----------------------------------------------------------------------------
// rxlrb_front
// Accepts items, drops ignored bytes, queues the rest for the back end.
// ----------------------------------------------------------------------------
module rxlrb_front (
	input  logic                               clk,
	input  logic                               arst_n,
	rxlrb_in_if.sink                           cmd,
	input  logic                               cfg_we,
	input  logic [rxlrb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rxlrb_pkg::CFG_DATA_W-1:0]   cfg_data,
	output rxlrb_pkg::cmdq_t                   head,
	input  logic                               pop
);

	logic [2:0]       ign_cnt_q;
	logic [7:0]       ign_char_q [rxlrb_pkg::NUM_IGNORE];
	rxlrb_pkg::cmd_t  queue_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;
	logic             ignored;
	logic             accept;
	logic             push;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ign_cnt_q <= '0;
			for (int k = 0; k < rxlrb_pkg::NUM_IGNORE; k++) begin
				ign_char_q[k] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				rxlrb_pkg::CFG_IGNORE_COUNT:  ign_cnt_q     <= cfg_data[2:0];
				rxlrb_pkg::CFG_IGNORE_CHAR_A: ign_char_q[0] <= cfg_data;
				rxlrb_pkg::CFG_IGNORE_CHAR_B: ign_char_q[1] <= cfg_data;
				rxlrb_pkg::CFG_IGNORE_CHAR_C: ign_char_q[2] <= cfg_data;
				rxlrb_pkg::CFG_IGNORE_CHAR_D: ign_char_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// counts above four cover all four slots
	always_comb begin
		ignored = 1'b0;
		for (int k = 0; k < rxlrb_pkg::NUM_IGNORE; k++) begin
			if ((ign_cnt_q > 3'(k)) && (ign_char_q[k] == cmd.rx_byte)) begin
				ignored = 1'b1;
			end
		end
	end

	assign cmd.ready = (cnt_q != 2'd2);
	assign accept    = cmd.valid && cmd.ready;
	assign push      = accept && !((cmd.op == rxlrb_pkg::OP_BYTE) && ignored);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_q] <= '{op: cmd.op, data: cmd.rx_byte};
		end
	end

	assign head.valid = (cnt_q != 2'd0);
	assign head.cmd   = queue_q[rd_q];

endmodule

### design/rxlrb_back.sv
// ----------------------------------------------------------------------------
// rxlrb_back
// Executes queued commands: ring writes, line streaming, result buffering.
// ----------------------------------------------------------------------------
module rxlrb_back #(
	parameter int RX_DEPTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  rxlrb_pkg::cmdq_t head,
	output logic             pop,
	rxlrb_out_if.source      rsp
);

	localparam int AW = $clog2(RX_DEPTH);

	rxlrb_pkg::back_state_t state_q, state_d;

	logic [AW-1:0] wr_idx_q;
	logic [AW-1:0] old_idx_q;
	logic [AW-1:0] nl_idx_q;
	logic          nlv_q;
	logic [AW-1:0] rd_ptr_q;

	logic          ram_we;
	logic          issue;
	logic          noline;
	logic          start;
	logic          is_last;
	logic          can_issue;
	logic [7:0]    ram_rdata;

	logic          vld_s1;
	logic          noline_s1;
	logic          last_s1;

	rxlrb_pkg::rsp_t fifo_q [2];
	logic            fwr_q;
	logic            frd_q;
	logic [1:0]      fcnt_q;
	logic [1:0]      occ;
	logic            fpop;
	logic [AW-1:0]   wr_nxt;

	function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
		return (i == AW'(RX_DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	assign fpop      = rsp.valid && rsp.ready;
	// result slots occupied after this cycle's push and pop
	assign occ       = fcnt_q + {1'b0, vld_s1} - {1'b0, fpop};
	assign can_issue = (occ < 2'd2);
	assign wr_nxt    = ring_next(wr_idx_q);

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		ram_we  = 1'b0;
		issue   = 1'b0;
		noline  = 1'b0;
		start   = 1'b0;
		is_last = 1'b0;
		case (state_q)
			rxlrb_pkg::BK_IDLE: begin
				if (head.valid) begin
					if (head.cmd.op == rxlrb_pkg::OP_BYTE) begin
						pop    = 1'b1;
						ram_we = 1'b1;
					end else if (can_issue) begin
						pop = 1'b1;
						if (!nlv_q) begin
							noline = 1'b1;
						end else begin
							start   = 1'b1;
							state_d = rxlrb_pkg::BK_STREAM;
						end
					end
				end
			end
			rxlrb_pkg::BK_STREAM: begin
				if (can_issue) begin
					issue   = 1'b1;
					is_last = (rd_ptr_q == nl_idx_q);
					if (is_last) begin
						state_d = rxlrb_pkg::BK_IDLE;
					end
				end
			end
			default: state_d = rxlrb_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rxlrb_pkg::BK_IDLE;
			wr_idx_q  <= '0;
			old_idx_q <= '0;
			nl_idx_q  <= '0;
			nlv_q     <= 1'b0;
			rd_ptr_q  <= '0;
			vld_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue || noline;
			if (ram_we) begin
				wr_idx_q <= wr_nxt;
				if (head.cmd.data == rxlrb_pkg::NEWLINE_CHAR) begin
					nl_idx_q <= wr_idx_q;
					nlv_q    <= 1'b1;
				end else if (nlv_q && (wr_nxt == nl_idx_q)) begin
					nlv_q <= 1'b0;
				end
				if (wr_nxt == old_idx_q) begin
					old_idx_q <= ring_next(old_idx_q);
				end
			end
			if (start) begin
				rd_ptr_q <= old_idx_q;
			end
			if (issue) begin
				rd_ptr_q <= ring_next(rd_ptr_q);
				if (is_last) begin
					old_idx_q <= ring_next(nl_idx_q);
					nlv_q     <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		noline_s1 <= noline;
		last_s1   <= is_last || noline;
	end

	rxlrb_ram #(
		.WIDTH (8),
		.DEPTH (RX_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_idx_q),
		.wdata (head.cmd.data),
		.re    (issue),
		.raddr (rd_ptr_q),
		.rdata (ram_rdata)
	);

	// two-entry result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwr_q  <= 1'b0;
			frd_q  <= 1'b0;
			fcnt_q <= '0;
		end else begin
			if (vld_s1) begin
				fwr_q <= ~fwr_q;
			end
			if (fpop) begin
				frd_q <= ~frd_q;
			end
			fcnt_q <= occ;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			fifo_q[fwr_q].status    <= noline_s1 ? rxlrb_pkg::STATUS_NO_LINE
				: rxlrb_pkg::STATUS_DATA;
			fifo_q[fwr_q].line_byte <= noline_s1 ? 8'h00 : ram_rdata;
			fifo_q[fwr_q].last_byte <= last_s1;
		end
	end

	assign rsp.valid     = (fcnt_q != 2'd0);
	assign rsp.status    = fifo_q[frd_q].status;
	assign rsp.line_byte = fifo_q[frd_q].line_byte;
	assign rsp.last_byte = fifo_q[frd_q].last_byte;

	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q != 2'd3)
		else $error("result queue overfilled");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (fcnt_q != 2'd2 || fpop))
		else $error("read data arrived with no result slot");

	a_stream_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rxlrb_pkg::BK_STREAM) |-> nlv_q)
		else $error("streaming without a recorded newline");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && is_last) |=> (!nlv_q && state_q == rxlrb_pkg::BK_IDLE))
		else $error("line end did not clear the newline mark");

endmodule

### design/rx_line_ring_buffer.sv
// ----------------------------------------------------------------------------
// rx_line_ring_buffer
// Line-framed receive ring buffer with configurable ignored characters.
// ----------------------------------------------------------------------------
// Each item on cmd is either a received byte (op 0) or a line request
// (op 1). The front end takes an item every cycle while its two-entry
// command queue has room; bytes matching one of the active ignore
// characters are dropped there and cost no back-end time. In the back end a
// stored byte is one RAM write plus pointer update. A line request is
// dispatched, then its bytes are read out through the single RAM read port,
// paced by the two-entry result queue on rsp; a request with no recorded
// newline yields a single no-line result. The ring RAM needs no clearing
// pass: a run only reads entries already written.
// ----------------------------------------------------------------------------
module rx_line_ring_buffer #(
	parameter int RX_DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	rxlrb_in_if.sink                         cmd,
	rxlrb_out_if.source                      rsp,
	input  logic                             cfg_we,
	input  logic [rxlrb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rxlrb_pkg::CFG_DATA_W-1:0] cfg_data
);

	// queue head from front to back, and its pop strobe
	rxlrb_pkg::cmdq_t head;
	logic             pop;

	// front: config registers, ignore filter, command queue
	rxlrb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.head      (head),
		.pop       (pop)
	);

	// back: ring pointers, store, line streaming, result queue
	rxlrb_back #(
		.RX_DEPTH (RX_DEPTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.rsp    (rsp)
	);

endmodule

### dv/rx_line_ring_buffer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rx_line_ring_buffer_tb
// Self-checking bench for the line-framed receive ring buffer. A directed
// table covers reset, field extremes and no-line replies. Random line traffic
// then runs under several ignore-character settings with jitter on both
// channels and one long output stall. Every result is checked field by field
// against an in-bench predictor of the ring.
// ----------------------------------------------------------------------------
module rx_line_ring_buffer_tb;

	localparam int RING_DEPTH    = 64;
	localparam int PTR_W         = $clog2(RING_DEPTH);
	localparam int SETTLE_CYCLES = 10;   // 2-entry cmd queue + back end, with margin
	localparam int LONG_HOLD     = 200;  // receiver hold-off for the pressure burst
	localparam int NUM_PHASES    = 6;
	localparam int PHASE_ITEMS   = 20;

	// directed row: item fields plus an optional hand-written expectation
	typedef struct packed {
		logic op;
		logic [7:0] data;
		logic typed;
		rxlrb_pkg::rsp_t want;
	} stim_row_t;

	localparam rxlrb_pkg::rsp_t NO_LINE_RSP =
		'{rxlrb_pkg::STATUS_NO_LINE, 8'h00, 1'b1};
	localparam rxlrb_pkg::rsp_t LONE_NL_RSP =
		'{rxlrb_pkg::STATUS_DATA, rxlrb_pkg::NEWLINE_CHAR, 1'b1};
	localparam rxlrb_pkg::rsp_t NO_RSP      = '0;

	localparam logic OP_B = rxlrb_pkg::OP_BYTE;
	localparam logic OP_L = rxlrb_pkg::OP_LINE;

	localparam int STIM_ROWS = 19;
	localparam stim_row_t STIM_TAB [STIM_ROWS] = '{
		'{OP_L, 8'h00, 1'b1, NO_LINE_RSP},  // nothing stored after reset
		'{OP_B, 8'h0A, 1'b0, NO_RSP},
		'{OP_L, 8'hFF, 1'b1, LONE_NL_RSP},  // line of just the newline
		'{OP_L, 8'h00, 1'b1, NO_LINE_RSP},  // mark consumed by previous run
		'{OP_B, 8'h00, 1'b0, NO_RSP},
		'{OP_B, 8'hFF, 1'b0, NO_RSP},
		'{OP_B, 8'h55, 1'b0, NO_RSP},
		'{OP_B, 8'hAA, 1'b0, NO_RSP},
		'{OP_B, 8'h0A, 1'b0, NO_RSP},
		'{OP_L, 8'h00, 1'b0, NO_RSP},
		'{OP_B, 8'h41, 1'b0, NO_RSP},
		'{OP_B, 8'h0A, 1'b0, NO_RSP},
		'{OP_B, 8'h42, 1'b0, NO_RSP},
		'{OP_B, 8'h0A, 1'b0, NO_RSP},
		'{OP_L, 8'h00, 1'b0, NO_RSP},       // two lines pending: run to latest newline
		'{OP_B, 8'h43, 1'b0, NO_RSP},
		'{OP_L, 8'h5A, 1'b1, NO_LINE_RSP},  // bytes held but no newline yet
		'{OP_B, 8'h0A, 1'b0, NO_RSP},
		'{OP_L, 8'hA5, 1'b0, NO_RSP}        // held byte comes out with this line
	};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [rxlrb_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [rxlrb_pkg::CFG_DATA_W-1:0] cfg_data;

	rxlrb_in_if  cmd_if();
	rxlrb_out_if rsp_if();

	rx_line_ring_buffer #(
		.RX_DEPTH(RING_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_if),
		.rsp(rsp_if),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// ------------------------------------------------------------------------
	// Predictor state: ring contents, pointers, newline mark, ignore settings
	// ------------------------------------------------------------------------
	logic [7:0]       ring_mem [RING_DEPTH];
	logic [PTR_W-1:0] wr_ptr = '0;
	logic [PTR_W-1:0] old_ptr = '0;
	logic [PTR_W-1:0] nl_ptr = '0;
	bit               nl_seen = 1'b0;
	logic [2:0]       drop_count = '0;
	logic [7:0]       drop_chars [rxlrb_pkg::NUM_IGNORE];

	rxlrb_pkg::rsp_t run_bytes [$];  // results of the item just accepted
	rxlrb_pkg::rsp_t due_bytes [$];  // results still owed by the block, oldest first

	bit in_jitter = 1'b0;
	bit out_jitter = 1'b0;
	bit long_hold_req = 1'b0;
	int phase_items;
	int bad_count = 0;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// ignore count saturates at four; chars past the count are not compared
	function automatic bit is_dropped(input logic [7:0] b);
		int n;
		n = (drop_count > 3'd4) ? 4 : int'(drop_count);
		for (int k = 0; k < n; k++)
			if (drop_chars[k] == b)
				return 1'b1;
		return 1'b0;
	endfunction

	// Advance the ring by one item; fills run_bytes with what it should emit.
	function automatic void rx_ring_step(input logic op, input logic [7:0] b);
		int span;
		logic [PTR_W-1:0] pos;
		rxlrb_pkg::rsp_t r;
		run_bytes.delete();
		if (op == rxlrb_pkg::OP_BYTE) begin
			if (is_dropped(b))
				return;
			ring_mem[wr_ptr] = b;
			if (b == rxlrb_pkg::NEWLINE_CHAR) begin
				nl_ptr = wr_ptr;
				nl_seen = 1'b1;
			end
			wr_ptr = ring_next(wr_ptr);
			// writer ran over the newline: that line is gone
			if (nl_seen && wr_ptr == nl_ptr)
				nl_seen = 1'b0;
			// writer caught the oldest byte: drop it
			if (wr_ptr == old_ptr)
				old_ptr = ring_next(old_ptr);
		end else if (!nl_seen) begin
			run_bytes.push_back(NO_LINE_RSP);
		end else begin
			span = ((int'(nl_ptr) + RING_DEPTH - int'(old_ptr)) % RING_DEPTH) + 1;
			pos = old_ptr;
			for (int k = 0; k < span; k++) begin
				r.status = rxlrb_pkg::STATUS_DATA;
				r.line_byte = ring_mem[pos];
				r.last_byte = (k == span - 1);
				run_bytes.push_back(r);
				pos = ring_next(pos);
			end
			old_ptr = ring_next(nl_ptr);
			nl_seen = 1'b0;
		end
	endfunction

	// mostly random, with a fair share of the configured ignore chars
	function automatic logic [7:0] pick_byte();
		if ($urandom_range(0, 3) == 0)
			return drop_chars[$urandom_range(0, rxlrb_pkg::NUM_IGNORE - 1)];
		return 8'($urandom_range(0, 255));
	endfunction

	// ------------------------------------------------------------------------
	// Command side. Valid stays high across back-to-back items; a gap lowers
	// it at the edge where the previous item was taken.
	// ------------------------------------------------------------------------
	task automatic send_item(input logic op, input logic [7:0] b,
		input bit typed = 1'b0, input rxlrb_pkg::rsp_t want = '0);
		int gap;
		gap = in_jitter ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			cmd_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.op <= op;
		cmd_if.rx_byte <= b;
		do @(posedge clk); while (cmd_if.ready !== 1'b1);
		// dropped bytes do no work, so they don't count toward the phase
		if (op == rxlrb_pkg::OP_LINE || !is_dropped(b))
			phase_items++;
		rx_ring_step(op, b);
		if (typed)
			due_bytes.push_back(want);
		else
			foreach (run_bytes[k])
				due_bytes.push_back(run_bytes[k]);
	endtask

	task automatic send_line(input int body, input bit tail);
		for (int i = 0; i < body; i++)
			send_item(rxlrb_pkg::OP_BYTE, pick_byte());
		send_item(rxlrb_pkg::OP_BYTE, rxlrb_pkg::NEWLINE_CHAR);
		if (tail)
			repeat ($urandom_range(1, 2)) send_item(rxlrb_pkg::OP_BYTE, pick_byte());
		send_item(rxlrb_pkg::OP_LINE, 8'($urandom_range(0, 255)));
	endtask

	// Quiet the command side, collect every owed result, then let the
	// back end finish any byte writes that produce nothing.
	task automatic drain_and_settle();
		cmd_if.valid <= 1'b0;
		while (due_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [rxlrb_pkg::CFG_IDX_W-1:0] idx,
		input logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx == rxlrb_pkg::CFG_IGNORE_COUNT)
			drop_count = val[2:0];
		else
			drop_chars[idx - rxlrb_pkg::CFG_IGNORE_CHAR_A] = val;
	endtask

	// ------------------------------------------------------------------------
	// Result side: per-item random hold-off, plus one long stall on request
	// ------------------------------------------------------------------------
	initial begin
		int hold;
		rsp_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = out_jitter ? $urandom_range(0, 3) : 0;
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold = LONG_HOLD;
			end
			if (hold > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (rsp_if.valid !== 1'b1);
		end
	end

	// result checker: every accepted result against the oldest owed one
	always @(posedge clk) begin
		rxlrb_pkg::rsp_t want;
		if (arst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
			if (due_bytes.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual %0d %02h %0d",
					$time, rsp_if.status, rsp_if.line_byte, rsp_if.last_byte);
				bad_count++;
			end else begin
				want = due_bytes.pop_front();
				if (rsp_if.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, rsp_if.status);
					bad_count++;
				end
				if (rsp_if.line_byte !== want.line_byte) begin
					$display("%0t: line_byte expected %02h actual %02h",
						$time, want.line_byte, rsp_if.line_byte);
					bad_count++;
				end
				if (rsp_if.last_byte !== want.last_byte) begin
					$display("%0t: last_byte expected %0d actual %0d",
						$time, want.last_byte, rsp_if.last_byte);
					bad_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		int kind;
		logic [2:0] cnt;
		logic [7:0] ch [rxlrb_pkg::NUM_IGNORE];

		arst_n = 1'b0;
		cmd_if.valid = 1'b0;
		cmd_if.op = rxlrb_pkg::OP_BYTE;
		cmd_if.rx_byte = 8'h00;
		cfg_we = 1'b0;
		cfg_index = rxlrb_pkg::CFG_IGNORE_COUNT;
		cfg_data = '0;
		foreach (ring_mem[i])
			ring_mem[i] = 8'h00;
		foreach (drop_chars[i])
			drop_chars[i] = 8'h00;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table under reset configuration (nothing ignored)
		for (int i = 0; i < STIM_ROWS; i++)
			send_item(STIM_TAB[i].op, STIM_TAB[i].data, STIM_TAB[i].typed,
				STIM_TAB[i].want);

		for (int p = 0; p < NUM_PHASES; p++) begin
			drain_and_settle();
			foreach (ch[i])
				ch[i] = 8'($urandom_range(0, 255));
			case (p)
				0: begin  // nothing ignored, all chars zero
					cnt = 3'd0;
					foreach (ch[i])
						ch[i] = 8'h00;
				end
				1: begin  // all four active, extremes and newline itself dropped
					cnt = 3'd4;
					ch[0] = 8'h00;
					ch[1] = 8'hFF;
					ch[2] = rxlrb_pkg::NEWLINE_CHAR;
					ch[3] = 8'h20;
				end
				2: cnt = 3'd7;  // count above four saturates
				3: begin  // c and d hold live values but sit past the count
					cnt = 3'd2;
					ch[3] = rxlrb_pkg::NEWLINE_CHAR;
				end
				4: cnt = 3'd1;
				default: cnt = 3'd3;
			endcase
			cfg_write(rxlrb_pkg::CFG_IGNORE_COUNT, {5'b0, cnt});
			cfg_write(rxlrb_pkg::CFG_IGNORE_CHAR_A, ch[0]);
			cfg_write(rxlrb_pkg::CFG_IGNORE_CHAR_B, ch[1]);
			cfg_write(rxlrb_pkg::CFG_IGNORE_CHAR_C, ch[2]);
			cfg_write(rxlrb_pkg::CFG_IGNORE_CHAR_D, ch[3]);
			cfg_we <= 1'b0;

			// phase 0 runs with no jitter at all
			in_jitter = (p != 0) && (p != 2);
			out_jitter = (p != 0) && (p != 3);

			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				kind = $urandom_range(0, 19);
				case (kind) inside
					[0:11]:
						send_line($urandom_range(0, 12), $urandom_range(0, 3) == 0);
					[12:13]:
						send_item(rxlrb_pkg::OP_LINE, 8'($urandom_range(0, 255)));
					[14:17]:  // loose noise
						repeat ($urandom_range(1, 6))
							send_item(1'($urandom_range(0, 1)),
								($urandom_range(0, 7) == 0) ?
								rxlrb_pkg::NEWLINE_CHAR : pick_byte());
					18: begin  // flood past a full ring; may run over the newline
						if ($urandom_range(0, 1))
							send_item(rxlrb_pkg::OP_BYTE, rxlrb_pkg::NEWLINE_CHAR);
						repeat ($urandom_range(62, 66))
							send_item(rxlrb_pkg::OP_BYTE, pick_byte());
						if ($urandom_range(0, 1))
							send_item(rxlrb_pkg::OP_BYTE, rxlrb_pkg::NEWLINE_CHAR);
						send_item(rxlrb_pkg::OP_LINE, 8'($urandom_range(0, 255)));
					end
					default:
						send_line($urandom_range(40, 63), 1'b0);
				endcase
			end

			if (p == 0) begin
				// Long output stall while long lines keep coming: result queue
				// backs up, the back end stops, and the command side stalls.
				// The first line fills the whole ring.
				long_hold_req = 1'b1;
				send_line(RING_DEPTH - 1, 1'b0);
				send_line(40, 1'b0);
				send_line(20, 1'b1);
			end
		end

		drain_and_settle();
		if (bad_count == 0)
			$display("rx_line_ring_buffer_tb passed");
		else
			$display("rx_line_ring_buffer_tb failed");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("rx_line_ring_buffer_tb failed");
		$finish;
	end

endmodule
